// ----- sv/osp_pkg.sv -----
// Shared types, constants and helper functions for the overlapping segment pair finder.
package osp_pkg;

  // Default store capacity and the fixed coordinate width.
  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 12;

  typedef logic [COORD_BITS-1:0] coord_t;

  // One input transaction.
  typedef struct packed {
    logic   frame_start;
    coord_t seg_ax;
    coord_t seg_ay;
    coord_t seg_bx;
    coord_t seg_by;
  } seg_in_t;

  // One result transaction.
  typedef struct packed {
    coord_t old_ax;
    coord_t old_ay;
    coord_t old_bx;
    coord_t old_by;
    coord_t new_ax;
    coord_t new_ay;
    coord_t new_bx;
    coord_t new_by;
    logic   last_pair;
  } seg_out_t;

  // A stored segment.
  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  // A classified segment waiting in the queue between front and back.
  typedef struct packed {
    logic   frame_start;
    seg_t   seg;
    coord_t lo;
    coord_t hi;
  } queue_entry_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic         vld;
    queue_entry_t entry;
  } queue_head_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

  // Lower end of a segment's x-extent.
  function automatic coord_t x_lo(input coord_t ax, input coord_t bx);
    return (ax < bx) ? ax : bx;
  endfunction

  // Upper end of a segment's x-extent.
  function automatic coord_t x_hi(input coord_t ax, input coord_t bx);
    return (ax < bx) ? bx : ax;
  endfunction

endpackage

// ----- sv/overlapping_segment_pair_finder.sv -----
// Top level of the overlapping segment pair finder.
//
// Input channel (in_valid/in_ready/in_data) takes one segment per transaction.
// A set frame_start empties the stored set before that segment is compared.
// Each segment's x-extent is tested against every segment stored earlier in
// the frame; each overlap gives one result transaction on the output channel
// (out_valid/out_ready/out_data), earliest stored segment first, with
// last_pair set on the final result of that segment.
// A segment is stored after its scan while the store has room.
// A two-entry queue lets the input side keep accepting while the scan runs.
// The scan reads one stored entry per cycle from the store's single read port,
// except while it holds on an overlap that the output cannot yet take. A found
// pair is held until the next overlap or the end of the scan settles its
// last_pair flag.
// Reset empties the store, the queue and the output register.
// When the receiver stalls, the scan holds on the next overlap found while a
// pair is pending, and input transactions are taken until the queue is full.
module overlapping_segment_pair_finder #(
  parameter int MAX_SEGMENTS = osp_pkg::MAX_SEGMENTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  osp_pkg::seg_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output osp_pkg::seg_out_t out_data
);

  osp_pkg::queue_head_t q_head;
  logic                 q_pop;

  // Intake and classification.
  osp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  // Scan of the stored set and result output.
  osp_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/osp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module osp_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/osp_front.sv -----
// Front end: accepts segments, computes their x-extents and queues them for the back end.
module osp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  osp_pkg::seg_in_t     in_data,
  input  logic                 q_pop,
  output osp_pkg::queue_head_t q_head
);

  localparam int QDEPTH = 2;

  osp_pkg::queue_entry_t q_mem_r [QDEPTH];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            q_cnt_r, q_cnt_nxt;
  logic                  push;
  osp_pkg::queue_entry_t new_entry;

  // Classify the incoming segment by its x-extent.
  always_comb begin
    new_entry.frame_start = in_data.frame_start;
    new_entry.seg.ax      = in_data.seg_ax;
    new_entry.seg.ay      = in_data.seg_ay;
    new_entry.seg.bx      = in_data.seg_bx;
    new_entry.seg.by      = in_data.seg_by;
    new_entry.lo          = osp_pkg::x_lo(in_data.seg_ax, in_data.seg_bx);
    new_entry.hi          = osp_pkg::x_hi(in_data.seg_ax, in_data.seg_bx);
  end

  assign in_ready = (q_cnt_r != 2'(QDEPTH));
  assign push     = in_valid && in_ready;

  // Queue pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    q_cnt_nxt  = q_cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_entry;
    end
  end

  assign q_head.vld   = (q_cnt_r != 2'd0);
  assign q_head.entry = q_mem_r[rd_ptr_r];

endmodule

// ----- sv/osp_back.sv -----
// Back end: scans the stored segments for each queued segment and emits overlapping pairs.
module osp_back #(
  parameter int MAX_SEGMENTS = osp_pkg::MAX_SEGMENTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  osp_pkg::queue_head_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output osp_pkg::seg_out_t    out_data
);

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = $bits(osp_pkg::seg_t);

  osp_pkg::back_state_t  state_r, state_nxt;
  osp_pkg::queue_entry_t cur_r, cur_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  b_vld_r, b_vld_nxt;
  logic                  pend_vld_r, pend_vld_nxt;
  osp_pkg::seg_t         pend_r, pend_nxt;
  logic                  out_vld_r, out_vld_nxt;
  osp_pkg::seg_out_t     out_r, out_nxt;

  logic                  ram_we;
  logic                  ram_re;
  logic [SW-1:0]         ram_rdata;
  osp_pkg::seg_t         old_seg;
  osp_pkg::coord_t       old_lo;
  osp_pkg::coord_t       old_hi;
  logic                  hit;
  logic                  out_free;
  logic                  stall;
  logic                  scan_end;
  logic                  done_go;

  // Segment store.
  osp_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_SEGMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (cur_r.seg),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Overlap test of the entry just read against the current segment.
  always_comb begin
    old_seg  = osp_pkg::seg_t'(ram_rdata);
    old_lo   = osp_pkg::x_lo(old_seg.ax, old_seg.bx);
    old_hi   = osp_pkg::x_hi(old_seg.ax, old_seg.bx);
    hit      = b_vld_r && (old_lo < cur_r.hi) && (cur_r.lo < old_hi);
    out_free = !out_vld_r || out_ready;
    stall    = hit && pend_vld_r && !out_free;
    scan_end = (idx_r == count_r) && !b_vld_r;
    done_go  = !pend_vld_r || out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      osp_pkg::BK_IDLE: begin
        if (q_head.vld) begin
          state_nxt = osp_pkg::BK_SCAN;
        end
      end
      osp_pkg::BK_SCAN: begin
        if (scan_end) begin
          state_nxt = osp_pkg::BK_DONE;
        end
      end
      osp_pkg::BK_DONE: begin
        if (done_go) begin
          state_nxt = osp_pkg::BK_IDLE;
        end
      end
      default: state_nxt = osp_pkg::BK_IDLE;
    endcase
  end

  // Datapath and output controls.
  always_comb begin
    cur_nxt      = cur_r;
    count_nxt    = count_r;
    idx_nxt      = idx_r;
    b_vld_nxt    = b_vld_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    case (state_r)
      osp_pkg::BK_IDLE: begin
        if (q_head.vld) begin
          q_pop     = 1'b1;
          cur_nxt   = q_head.entry;
          idx_nxt   = '0;
          b_vld_nxt = 1'b0;
          if (q_head.entry.frame_start) begin
            count_nxt = '0;
          end
        end
      end
      osp_pkg::BK_SCAN: begin
        if (!stall) begin
          ram_re    = (idx_r != count_r);
          b_vld_nxt = ram_re;
          idx_nxt   = idx_r + CW'(ram_re);
          if (hit) begin
            // A further hit means the pending pair was not the last one.
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = {pend_r, cur_r.seg, 1'b0};
            end
            pend_vld_nxt = 1'b1;
            pend_nxt     = old_seg;
          end
        end
      end
      osp_pkg::BK_DONE: begin
        if (done_go) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_nxt      = {pend_r, cur_r.seg, 1'b1};
            pend_vld_nxt = 1'b0;
          end
          // Store the segment when there is room.
          if (count_r < CW'(MAX_SEGMENTS)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
      end
      default: begin
        pend_vld_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= osp_pkg::BK_IDLE;
      count_r    <= '0;
      b_vld_r    <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      b_vld_r    <= b_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
